// ===== hw/rtl/see_pkg.sv =====
// ----------------------------------------------------------------------------
// see_pkg
// Shared constants and types for the squared Euclidean distance block.
// ----------------------------------------------------------------------------
package see_pkg;

    localparam int MAX_DIMENSIONS = 1024;
    localparam int LANES          = 4;
    localparam int ELEMENT_BITS   = 16;

    localparam int ACC_W      = 48;
    localparam int LEN_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LANE_SHIFT = $clog2(LANES);
    localparam int GROUP_W    = $clog2(MAX_DIMENSIONS / LANES + 1);
    localparam int DIFF_W     = ELEMENT_BITS + 1;
    localparam int SQ_W       = 2 * ELEMENT_BITS;
    localparam int GSUM_W     = SQ_W + LANE_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HALT_ENABLE   = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0] VECTOR_LENGTH_RESET = LEN_W'(128);
    localparam logic [LEN_W-1:0] MAX_LEN             = LEN_W'(MAX_DIMENSIONS);

    typedef logic signed [ELEMENT_BITS-1:0] elem_t;
    typedef logic [SQ_W-1:0]                square_t;
    typedef logic [GSUM_W-1:0]              group_sum_t;
    typedef logic [ACC_W-1:0]               acc_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        acc_t limit;
    } see_tag_t;

endpackage

// ===== hw/rtl/see_lane.sv =====
// ----------------------------------------------------------------------------
// see_lane
// One lane: squared difference of an element pair, registered.
// ----------------------------------------------------------------------------
module see_lane (
    input  logic                aclk,
    input  logic                enable,
    input  see_pkg::elem_t      a,
    input  see_pkg::elem_t      b,
    output see_pkg::square_t    square
);
    import see_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [ELEMENT_BITS-1:0]  mag_trim;
    square_t                  square_reg;
    square_t                  square_next;

    always_comb begin
        diff        = DIFF_W'(a) - DIFF_W'(b);
        mag         = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag_trim    = mag[ELEMENT_BITS-1:0];
        square_next = SQ_W'(mag_trim) * SQ_W'(mag_trim);
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule

// ===== hw/rtl/see_merge.sv =====
// ----------------------------------------------------------------------------
// see_merge
// Merge stage: adds the lane squares into one group sum, registered with
// the group's tag.
// ----------------------------------------------------------------------------
module see_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  enable,
    input  see_pkg::square_t      square [see_pkg::LANES],
    input  see_pkg::see_tag_t     tag_in,
    output see_pkg::group_sum_t   group_sum,
    output see_pkg::see_tag_t     tag_out
);
    import see_pkg::*;

    group_sum_t sum_reg;
    group_sum_t sum_next;
    see_tag_t   tag_reg;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++) begin
            sum_next = sum_next + GSUM_W'(square[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.valid <= 1'b0;
        end else if (enable) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            sum_reg <= sum_next;
        end
    end

    assign group_sum = sum_reg;
    assign tag_out   = tag_reg;

endmodule

// ===== hw/rtl/see_accum.sv =====
// ----------------------------------------------------------------------------
// see_accum
// Accumulator with saturation, threshold compare and result register.
// ----------------------------------------------------------------------------
module see_accum (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  enable,
    input  logic                  halt_enable,
    input  see_pkg::group_sum_t   group_sum,
    input  see_pkg::see_tag_t     tag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [see_pkg::ACC_W-1:0] m_distance,
    output logic                  m_exceeded
);
    import see_pkg::*;

    acc_t         acc_reg;
    acc_t         acc_next;
    acc_t         limit_reg;
    acc_t         limit_next;
    logic         abandoned_reg;
    logic         abandoned_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    acc_t         out_distance_reg;
    logic         out_exceeded_reg;

    acc_t         acc_base;
    logic         abandoned_base;
    logic [ACC_W:0] sum_wide;
    acc_t         sum_sat;
    logic         load;

    always_comb begin
        acc_base       = tag.first ? '0 : acc_reg;
        abandoned_base = tag.first ? 1'b0 : abandoned_reg;
        limit_next     = tag.first ? tag.limit : limit_reg;
        sum_wide       = {1'b0, acc_base} + (ACC_W + 1)'(group_sum);
        sum_sat        = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
        if (abandoned_base) begin
            acc_next       = acc_base;
            abandoned_next = 1'b1;
        end else begin
            acc_next       = sum_sat;
            abandoned_next = halt_enable && (sum_sat > limit_next);
        end
        load = enable && tag.valid && tag.last;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            limit_reg     <= '0;
            abandoned_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (enable && tag.valid) begin
                acc_reg       <= acc_next;
                limit_reg     <= limit_next;
                abandoned_reg <= abandoned_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_distance_reg <= abandoned_next ? '1 : acc_next;
            out_exceeded_reg <= abandoned_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_distance = out_distance_reg;
    assign m_exceeded = out_exceeded_reg;

    a_exceeded_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_exceeded_reg |-> (&out_distance_reg))
        else $error("exceeded result without all-ones distance");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready && tag.valid && tag.last |-> !enable)
        else $error("pending result overwritten");

    a_abandon_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        abandoned_reg && enable && tag.valid && !tag.first |=> abandoned_reg)
        else $error("abandon cleared within a vector");

    a_acc_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        enable && tag.valid && !tag.first |=> acc_reg >= $past(acc_reg))
        else $error("accumulator decreased within a vector");

endmodule

// ===== hw/rtl/squared_euclidean_early_exit.sv =====
// ----------------------------------------------------------------------------
// squared_euclidean_early_exit
// Squared Euclidean distance over streamed groups of four element pairs,
// with early abandon against a per-vector threshold.
//
//   channel  direction  ports                              transaction
//   s_       in         s_a_lane0..3, s_b_lane0..3, s_limit one group of pairs
//   m_       out        m_distance, m_exceeded              one vector result
//   cfg_     in         cfg_index, cfg_data                 one register write
//
// One group is accepted per cycle while s_ready is high; the lanes, merge
// adder and accumulator form a three-stage pipeline: a vector's last group
// passes the lane/tag and merge registers, then the result register sets
// m_valid. Synchronous active-low reset clears control state and restores
// vector_length 128, halt_enable 1. The pipeline holds only when a finished
// result waits and the next last group reaches the accumulator.
// ----------------------------------------------------------------------------
module squared_euclidean_early_exit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_a_lane0,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_a_lane1,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_a_lane2,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_a_lane3,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_b_lane0,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_b_lane1,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_b_lane2,
    input  logic signed [see_pkg::ELEMENT_BITS-1:0] s_b_lane3,
    input  logic [see_pkg::ACC_W-1:0]         s_limit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [see_pkg::ACC_W-1:0]         m_distance,
    output logic                              m_exceeded,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [see_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [see_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import see_pkg::*;

    logic [LEN_W-1:0]   vector_length_reg;
    logic               halt_enable_reg;
    logic [GROUP_W-1:0] count_reg;
    logic [GROUP_W-1:0] count_next;
    logic [GROUP_W-1:0] count_plus;
    logic [LEN_W-1:0]   len_clip;
    logic [GROUP_W-1:0] groups_raw;
    logic [GROUP_W-1:0] groups;
    logic               in_last;
    logic               accept;
    logic               enable;

    elem_t      a_lane [LANES];
    elem_t      b_lane [LANES];
    square_t    square [LANES];
    see_tag_t   tag0_reg;
    see_tag_t   tag0_next;
    see_tag_t   tag1;
    group_sum_t group_sum;

    assign a_lane[0] = s_a_lane0;
    assign a_lane[1] = s_a_lane1;
    assign a_lane[2] = s_a_lane2;
    assign a_lane[3] = s_a_lane3;
    assign b_lane[0] = s_b_lane0;
    assign b_lane[1] = s_b_lane1;
    assign b_lane[2] = s_b_lane2;
    assign b_lane[3] = s_b_lane3;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_length_reg <= VECTOR_LENGTH_RESET;
            halt_enable_reg   <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_VECTOR_LENGTH: vector_length_reg <= cfg_data[LEN_W-1:0];
                REG_HALT_ENABLE:   halt_enable_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // hold the whole pipeline while a pending result would be overwritten
    assign enable  = !(tag1.valid && tag1.last && m_valid && !m_ready);
    assign s_ready = enable;
    assign accept  = s_valid && s_ready;

    always_comb begin
        len_clip   = (vector_length_reg > MAX_LEN) ? MAX_LEN : vector_length_reg;
        groups_raw = GROUP_W'(len_clip >> LANE_SHIFT);
        groups     = (groups_raw == '0) ? GROUP_W'(1) : groups_raw;
        count_plus = count_reg + GROUP_W'(1);
        in_last    = count_plus >= groups;
        count_next = in_last ? '0 : count_plus;
        tag0_next.valid = accept;
        tag0_next.first = (count_reg == '0);
        tag0_next.last  = in_last;
        tag0_next.limit = s_limit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            tag0_reg.valid <= 1'b0;
        end else if (enable) begin
            tag0_reg <= tag0_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        see_lane u_lane (
            .aclk   (aclk),
            .enable (enable),
            .a      (a_lane[g]),
            .b      (b_lane[g]),
            .square (square[g])
        );
    end

    see_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .square    (square),
        .tag_in    (tag0_reg),
        .group_sum (group_sum),
        .tag_out   (tag1)
    );

    see_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .enable      (enable),
        .halt_enable (halt_enable_reg),
        .group_sum   (group_sum),
        .tag         (tag1),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_exceeded  (m_exceeded)
    );

endmodule
